// File: rtl/rmmsq_pkg.sv
// Shared types, request codes and controller states for the range spread query block.
package rmmsq_pkg;

  // Fixed field widths of the request and response transactions.
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned IDX_W    = 16;
  localparam int unsigned SPREAD_W = 32;

  // Request type codes.
  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // Request transaction payload.
  typedef struct packed {
    logic [REQ_W-1:0]          req_type;
    logic signed [VALUE_W-1:0] value;
    logic [IDX_W-1:0]          left_index;
    logic [IDX_W-1:0]          right_index;
  } req_t;

  // Response transaction payload.
  typedef struct packed {
    logic [SPREAD_W-1:0] spread;
    logic                status;
  } rsp_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LOAD_LVL,
    ST_Q_LOG,
    ST_Q_RD1,
    ST_Q_RD2,
    ST_Q_CMB,
    ST_Q_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic load_init;
    logic load_step;
    logic load_done;
    logic clear;
    logic q_err;
    logic q_len;
    logic q_log;
    logic q_rd1;
    logic q_rd2;
    logic q_cmb;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             full;
    logic             range_bad;
    logic             lvl_ok;
    logic             out_busy;
  } sts_t;

endpackage

// File: rtl/rmmsq_ctrl.sv
// Controller state machine that sequences loads, clears and range queries.
module rmmsq_ctrl import rmmsq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        case (sts.req_type)
          REQ_LOAD: begin
            state_next = sts.full ? ST_IDLE : ST_LOAD_LVL;
          end
          REQ_QUERY: begin
            state_next = sts.range_bad ? ST_Q_OUT : ST_Q_LOG;
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_LOAD_LVL: begin
        if (!sts.lvl_ok) state_next = ST_IDLE;
      end
      ST_Q_LOG: state_next = ST_Q_RD1;
      ST_Q_RD1: state_next = ST_Q_RD2;
      ST_Q_RD2: state_next = ST_Q_CMB;
      ST_Q_CMB: state_next = ST_Q_OUT;
      ST_Q_OUT: begin
        if (!sts.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
      end
      ST_DECODE: begin
        case (sts.req_type)
          REQ_LOAD: begin
            cmd.load_init = !sts.full;
          end
          REQ_QUERY: begin
            cmd.q_err = sts.range_bad;
            cmd.q_len = !sts.range_bad;
          end
          REQ_CLEAR: begin
            cmd.clear = 1'b1;
          end
          default: begin
          end
        endcase
      end
      ST_LOAD_LVL: begin
        cmd.load_step = sts.lvl_ok;
        cmd.load_done = !sts.lvl_ok;
      end
      ST_Q_LOG: cmd.q_log = 1'b1;
      ST_Q_RD1: cmd.q_rd1 = 1'b1;
      ST_Q_RD2: cmd.q_rd2 = 1'b1;
      ST_Q_CMB: cmd.q_cmb = 1'b1;
      ST_Q_OUT: cmd.out_load = !sts.out_busy;
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/rmmsq_dpath.sv
// Datapath: min and max doubling tables, element count, query arithmetic and response register.
module rmmsq_dpath import rmmsq_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = 65536,
  parameter int unsigned LEVELS       = 17,
  parameter int unsigned DATA_WIDTH   = 32
) (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  output rsp_t rsp,
  output logic rsp_valid,
  input  logic rsp_ready,
  input  cmd_t cmd,
  output sts_t sts
);

  localparam int unsigned DW        = DATA_WIDTH;
  localparam int unsigned AW        = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW        = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned SW        = CW + 1;
  localparam int unsigned LW        = $clog2(LEVELS);
  localparam int unsigned LVW       = $clog2(LEVELS + 1);
  localparam int unsigned MAW       = LW + AW;
  localparam int unsigned MEM_DEPTH = LEVELS * (2 ** AW);
  localparam int unsigned CMPW      = (CW > IDX_W) ? CW : IDX_W;

  // Tables: entry {level, start} holds the min / max of 2^level positions.
  logic signed [DW-1:0] min_mem [MEM_DEPTH];
  logic signed [DW-1:0] max_mem [MEM_DEPTH];

  req_t                 req_q;
  logic [CW-1:0]        count;
  logic [LVW-1:0]       lvl;
  logic [SW-1:0]        span;
  logic signed [DW-1:0] run_min;
  logic signed [DW-1:0] run_max;
  logic signed [DW-1:0] rd_min;
  logic signed [DW-1:0] rd_max;
  logic signed [DW-1:0] d1_min;
  logic signed [DW-1:0] d1_max;
  logic signed [DW-1:0] lo;
  logic signed [DW-1:0] hi;
  logic [IDX_W:0]       len;
  logic [LW-1:0]        qk;
  logic [AW-1:0]        s2;
  logic                 err;
  rsp_t                 rsp_q;
  logic                 rsp_valid_q;

  logic [CW-1:0]        pp1;
  logic [SW-1:0]        span2;
  logic [SW-1:0]        s_rd_step;
  logic [SW-1:0]        s_wr_step;
  logic [CW-1:0]        s_rd_init;
  logic signed [DW-1:0] val;
  logic signed [DW-1:0] step_min;
  logic signed [DW-1:0] step_max;
  logic [LW-1:0]        kc;
  logic [IDX_W:0]       r1;
  logic [IDX_W:0]       pw;
  logic [MAW-1:0]       rd_addr;
  logic [MAW-1:0]       wr_addr;
  logic                 mem_we;
  logic signed [DW-1:0] wr_min;
  logic signed [DW-1:0] wr_max;
  logic [DW:0]          diff;

  // Load arithmetic: window starts for the current level write and the next level read.
  assign pp1       = count + CW'(1);
  assign span2     = span << 1;
  assign s_wr_step = SW'(pp1) - span;
  assign s_rd_step = SW'(pp1) - span2;
  assign s_rd_init = pp1 - CW'(2);
  assign val       = req_q.value[DW-1:0];
  assign step_min  = (rd_min < run_min) ? rd_min : run_min;
  assign step_max  = (rd_max > run_max) ? rd_max : run_max;

  // Window level of a query: highest set bit of the length, clamped to the top level.
  always_comb begin
    kc = '0;
    for (int i = 0; i <= IDX_W; i++) begin
      if (len[i]) begin
        kc = (i < LEVELS) ? LW'(i) : LW'(LEVELS - 1);
      end
    end
  end

  // Start of the second query window.
  assign r1      = {1'b0, req_q.right_index} + (IDX_W + 1)'(1);
  assign pw      = (IDX_W + 1)'(1) << qk;

  // Table read address.
  always_comb begin
    rd_addr = {qk, AW'(req_q.left_index)};
    if (cmd.load_init) begin
      rd_addr = {LW'(0), AW'(s_rd_init)};
    end else if (cmd.load_step) begin
      rd_addr = {lvl[LW-1:0], AW'(s_rd_step)};
    end else if (cmd.q_rd2) begin
      rd_addr = {qk, s2};
    end
  end

  // Table write port.
  always_comb begin
    mem_we  = cmd.load_init | cmd.load_step;
    wr_addr = {lvl[LW-1:0], AW'(s_wr_step)};
    wr_min  = step_min;
    wr_max  = step_max;
    if (cmd.load_init) begin
      wr_addr = {LW'(0), AW'(count)};
      wr_min  = val;
      wr_max  = val;
    end
  end

  // Table memories with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      min_mem[wr_addr] <= wr_min;
      max_mem[wr_addr] <= wr_max;
    end
    rd_min <= min_mem[rd_addr];
    rd_max <= max_mem[rd_addr];
  end

  // Element count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.load_done) begin
      count <= pp1;
    end
  end

  // Request capture, load level walk and query registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req;
    end
    if (cmd.load_init) begin
      run_min <= val;
      run_max <= val;
      lvl     <= LVW'(1);
      span    <= SW'(2);
    end else if (cmd.load_step) begin
      run_min <= step_min;
      run_max <= step_max;
      lvl     <= lvl + LVW'(1);
      span    <= span2;
    end
    if (cmd.q_err) begin
      err <= 1'b1;
    end else if (cmd.q_len) begin
      err <= 1'b0;
      len <= {1'b0, req_q.right_index} - {1'b0, req_q.left_index} + (IDX_W + 1)'(1);
    end
    if (cmd.q_log) begin
      qk <= kc;
    end
    if (cmd.q_rd1) begin
      s2 <= AW'(r1 - pw);
    end
    if (cmd.q_rd2) begin
      d1_min <= rd_min;
      d1_max <= rd_max;
    end
    if (cmd.q_cmb) begin
      lo <= (d1_min < rd_min) ? d1_min : rd_min;
      hi <= (d1_max > rd_max) ? d1_max : rd_max;
    end
  end

  // Spread of the two combined windows, always non-negative.
  assign diff = {hi[DW-1], hi} - {lo[DW-1], lo};

  // Response register; it holds until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_q <= 1'b0;
    end
    if (cmd.out_load) begin
      rsp_q.spread <= err ? '0 : SPREAD_W'(diff);
      rsp_q.status <= err;
    end
  end

  assign rsp       = rsp_q;
  assign rsp_valid = rsp_valid_q;

  // Status for the controller.
  always_comb begin
    sts.req_type  = req_q.req_type;
    sts.full      = (count == CW'(MAX_ELEMENTS));
    sts.range_bad = (req_q.left_index > req_q.right_index) ||
                    (CMPW'(req_q.right_index) >= CMPW'(count));
    sts.lvl_ok    = (lvl < LVW'(LEVELS)) && (span <= SW'(pp1));
    sts.out_busy  = rsp_valid_q && !rsp_ready;
  end

endmodule

// File: rtl/range_max_min_spread_query.sv
// Top level of the sparse-table range spread query engine.
//
// Requests arrive on req (req_valid / req_ready); responses leave on rsp
// (rsp_valid / rsp_ready). A transaction is taken when valid and ready are
// both high at a rising clock edge.
// A load appends a value and fills one table entry per doubling level in a
// single pass, one level per cycle; the request side is held until the last
// level is written. The loop over levels runs on one read and one write
// port of each table.
// A query steps through decode, the level pick (ST_Q_LOG), two table reads
// (ST_Q_RD1, ST_Q_RD2), the combine (ST_Q_CMB) and the output (ST_Q_OUT); on
// a range error it goes from decode straight to output. The request side is
// held until the response is loaded. The two table reads run one after the
// other on the same port.
// Clears, ignored loads and unknown request types give no response.
// One request is worked on at a time. The response register parts the two
// sides: while the receiver stalls, new requests are still taken, and a query
// only waits in its final step until the previous response has been taken.
// Reset empties the table (count back to zero) and drops any pending
// response; table contents are not cleared and are only read once rewritten.
module range_max_min_spread_query import rmmsq_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = 65536,
  parameter int unsigned LEVELS       = 17,
  parameter int unsigned DATA_WIDTH   = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  cmd_t cmd;
  sts_t sts;

  // Sequencing.
  rmmsq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Tables and arithmetic.
  rmmsq_dpath #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .LEVELS       (LEVELS),
    .DATA_WIDTH   (DATA_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// File: tb/tb_range_max_min_spread_query.sv
// Self-checking testbench for the sparse-table range spread query engine.
module tb_range_max_min_spread_query import rmmsq_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // Capacity matches the block's default element count.
  localparam int unsigned CAPACITY      = 65536;
  localparam int unsigned RANDOM_ITEMS  = 720;
  localparam int unsigned LONG_RUN      = 1024;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned IDLE_PERCENT  = 28;

  // Request code with no meaning to the block, and response status codes.
  localparam logic [REQ_W-1:0] REQ_UNUSED       = 2'd3;
  localparam logic             STATUS_OK        = 1'b0;
  localparam logic             STATUS_RANGE_ERR = 1'b1;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // Mirror of the loaded list and the spreads still owed by the block.
  logic signed [VALUE_W-1:0] loaded_values [CAPACITY];
  int unsigned               loaded_count = 0;
  rsp_t                      owed_spreads [$];
  rsp_t                      oldest_spread;

  bit          idle_on          = 1'b1;
  int unsigned error_count      = 0;
  int unsigned checked_count    = 0;
  int unsigned loads_accepted   = 0;
  int unsigned queries_sent     = 0;
  int unsigned range_errors     = 0;
  int unsigned clears_sent      = 0;

  range_max_min_spread_query u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // Receiver side: stall at random unless idling is switched off.
  always @(negedge clk) begin
    rsp_ready <= idle_on ? ($urandom_range(99) >= IDLE_PERCENT) : 1'b1;
  end

  // Max minus min over an inclusive range, or a range error.
  function automatic rsp_t range_spread(int unsigned left, int unsigned right);
    rsp_t                      res;
    logic signed [VALUE_W-1:0] lo;
    logic signed [VALUE_W-1:0] hi;
    longint                    diff;
    res.spread = '0;
    res.status = STATUS_RANGE_ERR;
    if (left > right || right >= loaded_count) begin
      return res;
    end
    lo = loaded_values[left];
    hi = lo;
    for (int unsigned i = left + 1; i <= right; i++) begin
      if (loaded_values[i] < lo) lo = loaded_values[i];
      if (loaded_values[i] > hi) hi = loaded_values[i];
    end
    diff = longint'(hi) - longint'(lo);
    res.spread = diff[SPREAD_W-1:0];
    res.status = STATUS_OK;
    return res;
  endfunction

  // Update the mirror for one accepted request.
  task automatic apply_request(req_t item);
    rsp_t res;
    case (item.req_type)
      REQ_LOAD: begin
        if (loaded_count < CAPACITY) begin
          loaded_values[loaded_count] = item.value;
          loaded_count++;
          loads_accepted++;
        end
      end
      REQ_CLEAR: begin
        loaded_count = 0;
        clears_sent++;
      end
      REQ_QUERY: begin
        res = range_spread(item.left_index, item.right_index);
        owed_spreads.push_back(res);
        queries_sent++;
        if (res.status == STATUS_RANGE_ERR) range_errors++;
      end
      default: ;
    endcase
  endtask

  function automatic req_t build_request(logic [REQ_W-1:0] kind, logic [VALUE_W-1:0] value,
                                         logic [IDX_W-1:0] left, logic [IDX_W-1:0] right);
    req_t item;
    item.req_type    = kind;
    item.value       = value;
    item.left_index  = left;
    item.right_index = right;
    return item;
  endfunction

  // Values lean on the extremes and on small numbers that often repeat.
  function automatic logic [VALUE_W-1:0] random_value();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom_range(200) - 100;
      default: return $urandom;
    endcase
  endfunction

  // Drive one transaction and wait until the block takes it.
  task automatic send_request(req_t item);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
    apply_request(item);
  endtask

  task automatic send_query(int unsigned left, int unsigned right);
    send_request(build_request(REQ_QUERY, $urandom, left[IDX_W-1:0], right[IDX_W-1:0]));
  endtask

  task automatic send_load(logic [VALUE_W-1:0] value);
    send_request(build_request(REQ_LOAD, value, IDX_W'($urandom), IDX_W'($urandom)));
  endtask

  task automatic send_clear();
    send_request(build_request(REQ_CLEAR, $urandom, IDX_W'($urandom), IDX_W'($urandom)));
  endtask

  // Hold the request side until every owed response has come back.
  task automatic wait_for_results();
    @(negedge clk);
    req_valid <= 1'b0;
    while (owed_spreads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Compare each taken response with the oldest owed one.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (owed_spreads.size() == 0) begin
        $error("response with none owed: spread %0h status %0b", rsp.spread, rsp.status);
        error_count++;
      end else begin
        oldest_spread = owed_spreads.pop_front();
        checked_count++;
        if (rsp.spread !== oldest_spread.spread) begin
          $error("spread: expected %0h, got %0h", oldest_spread.spread, rsp.spread);
          error_count++;
        end
        if (rsp.status !== oldest_spread.status) begin
          $error("status: expected %0b, got %0b", oldest_spread.status, rsp.status);
          error_count++;
        end
      end
    end
  end

  // Empty table, extremes of value and index, bad ranges and unknown codes.
  task automatic test_directed_corners();
    send_query(0, 0);
    send_clear();
    send_load(32'h7FFF_FFFF);
    send_query(0, 0);
    send_load(32'h8000_0000);
    send_query(0, 1);
    send_load(32'h0000_0000);
    send_load(32'hFFFF_FFFF);
    send_load(32'h0000_0001);
    send_query(0, 4);
    send_query(2, 4);
    send_query(1, 3);
    send_query(3, 3);
    send_query(3, 1);
    send_query(0, 5);
    send_query(0, 16'hFFFF);
    send_query(16'hFFFF, 16'hFFFF);
    send_query(16'hFFFF, 0);
    send_request(build_request(REQ_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
    send_query(4, 4);
    send_clear();
    send_query(0, 0);
    send_load(32'h8000_0000);
    send_query(0, 0);
    wait_for_results();
  endtask

  // Episodes of loads followed by queries, with noise and occasional clears.
  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned n_loads;
    int unsigned n_queries;
    int unsigned pick;
    int unsigned left;
    int unsigned right;
    sent = 0;
    send_clear();
    while (sent < RANDOM_ITEMS) begin
      // A long stretch in the middle runs with no idling on either side.
      idle_on = !(sent >= 250 && sent < 450);
      if ($urandom_range(99) < 8 || loaded_count > 400) begin
        send_clear();
        sent++;
      end
      n_loads = ($urandom_range(9) == 0) ? $urandom_range(200, 64) : $urandom_range(24, 1);
      repeat (n_loads) send_load(random_value());
      sent += n_loads;
      n_queries = $urandom_range(20, 1);
      repeat (n_queries) begin
        pick = $urandom_range(99);
        if (pick < 80 && loaded_count > 0) begin
          left  = $urandom_range(loaded_count - 1);
          right = ($urandom_range(1) == 0) ?
                  $urandom_range(loaded_count - 1, left) :
                  ((left + $urandom_range(3) < loaded_count) ? left + $urandom_range(3) : left);
          send_query(left, right);
          sent++;
        end else if (pick < 88) begin
          right = $urandom_range(16'hFFFF, loaded_count);
          send_query($urandom_range(16'hFFFF), right);
          sent++;
        end else if (pick < 95) begin
          right = $urandom_range(16'hFFFE);
          send_query($urandom_range(16'hFFFF, right + 1), right);
          sent++;
        end else begin
          send_request(build_request(REQ_UNUSED, $urandom, IDX_W'($urandom),
                                     IDX_W'($urandom)));
        end
      end
      if ($urandom_range(15) == 0) wait_for_results();
    end
    idle_on = 1'b1;
    wait_for_results();
  endtask

  // A long run of loads that reaches table level 10, and ranges across it.
  task automatic test_long_run();
    int unsigned left;
    int unsigned right;
    idle_on = 1'b0;
    send_clear();
    for (int unsigned i = 0; i < LONG_RUN; i++) begin
      send_load(random_value());
    end
    send_query(0, LONG_RUN - 1);
    send_query(LONG_RUN - 1, LONG_RUN - 1);
    send_query(LONG_RUN / 2, LONG_RUN - 1);
    send_query(1, LONG_RUN - 2);
    send_query(0, LONG_RUN);
    idle_on = 1'b1;
    repeat (8) begin
      left  = $urandom_range(LONG_RUN - 1);
      right = $urandom_range(LONG_RUN - 1, left);
      send_query(left, right);
    end
    send_clear();
    send_query(0, 0);
    send_query(LONG_RUN - 1, LONG_RUN - 1);
    wait_for_results();
  endtask

  // Run limit well beyond the slowest correct run.
  initial begin
    #100ms;
    $display("range_max_min_spread_query test failed");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_corners();
    test_random_traffic();
    test_long_run();
    $display("Covered %0d loads, %0d clears and %0d queries, %0d of them bad ranges.",
             loads_accepted, clears_sent, queries_sent, range_errors);
    $display("Checked %0d responses, including a run of %0d loads with no clear between.",
             checked_count, LONG_RUN);
    if (error_count == 0) begin
      $display("range_max_min_spread_query test passed");
    end else begin
      $display("range_max_min_spread_query test failed");
    end
    $finish;
  end

endmodule
